// File: hdl/iebm_pkg.sv
// ----------------------------------------------------------------------------
// iebm_pkg: shared constants for the i2c eeprom byte master
// command codes, register indexes, register reset values and fixed bytes
// ----------------------------------------------------------------------------
package iebm_pkg;

    localparam int CmdWidth      = 2;
    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 8;
    localparam int ByteWidth     = 8;
    localparam int DevAddrWidth  = 7;
    localparam int BitCountWidth = 4;
    localparam int StageWidth    = 2;

    // command codes
    localparam logic [CmdWidth-1:0] CMD_TICK  = 2'd0;
    localparam logic [CmdWidth-1:0] CMD_WRITE = 2'd1;
    localparam logic [CmdWidth-1:0] CMD_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CfgIndexWidth-1:0] REG_DEVICE_ADDRESS  = 2'd0;
    localparam logic [CfgIndexWidth-1:0] REG_ACK_TIMEOUT     = 2'd1;
    localparam logic [CfgIndexWidth-1:0] REG_TICKS_PER_DELAY = 2'd2;

    // register reset values
    localparam logic [DevAddrWidth-1:0] RST_DEVICE_ADDRESS  = 7'd87;
    localparam logic [ByteWidth-1:0]    RST_ACK_TIMEOUT     = 8'd250;
    localparam logic [ByteWidth-1:0]    RST_TICKS_PER_DELAY = 8'd1;

    // byte stages of a transfer
    localparam logic [StageWidth-1:0] STAGE_DEVICE  = 2'd0;
    localparam logic [StageWidth-1:0] STAGE_ADDRESS = 2'd1;
    localparam logic [StageWidth-1:0] STAGE_LAST    = 2'd2;

    localparam logic [BitCountWidth-1:0] BITS_PER_BYTE = 4'd8;
    localparam logic [ByteWidth-1:0]     READ_FAIL_DATA = 8'hFF;

endpackage

// File: hdl/i2c_eeprom_byte_master.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master: bit-level i2c master for a byte-wide serial eeprom
// byte write and random read, stepped by one bus timing tick per transfer
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_ready): one transfer is one bus tick,
//   carrying a command, the eeprom address, the write byte and the sampled
//   sda level. a write or read command starts a transfer only from idle;
//   commands while busy, and code 3, act as a plain tick
//   output channel (o_out_valid / i_out_ready): exactly one result per tick,
//   with the line levels to drive, busy, done, success and the read byte
//   config channel (i_cfg_valid / o_cfg_ready): always ready, index 0 device
//   address, 1 acknowledge timeout, 2 ticks per delay unit
//   the result of each input transfer is registered; a tick is taken in
//   every cycle that the result register can take it, the whole
//   sequencer step sits between the input ports and the result register
//   when the receiver stalls, the result register holds and input is taken
//   only once the held result leaves in the same cycle
//   reset clears the sequencer to idle with both lines released high and the
//   registers at their defaults
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_master (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // tick channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [iebm_pkg::CmdWidth-1:0]         i_cmd,
    input  logic [iebm_pkg::ByteWidth-1:0]        i_mem_address,
    input  logic [iebm_pkg::ByteWidth-1:0]        i_write_data,
    input  logic                                  i_sda_in,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_scl_out,
    output logic                                  o_sda_out,
    output logic                                  o_busy_res,
    output logic                                  o_done_res,
    output logic                                  o_success,
    output logic [iebm_pkg::ByteWidth-1:0]        o_read_data,
    // configuration channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [iebm_pkg::CfgIndexWidth-1:0]    i_cfg_index,
    input  logic [iebm_pkg::CfgDataWidth-1:0]     i_cfg_data
);

    // bus sequence phases
    typedef enum logic [4:0] {
        PH_IDLE  = 5'd0,
        PH_S2    = 5'd1,
        PH_S3    = 5'd2,
        PH_WLOW  = 5'd3,
        PH_WDATA = 5'd4,
        PH_WHIGH = 5'd5,
        PH_WEND1 = 5'd6,
        PH_WEND2 = 5'd7,
        PH_ASET  = 5'd8,
        PH_ACHK  = 5'd9,
        PH_AFAIL = 5'd10,
        PH_AOK   = 5'd11,
        PH_RS1   = 5'd12,
        PH_R1    = 5'd13,
        PH_R2    = 5'd14,
        PH_R3    = 5'd15,
        PH_R4    = 5'd16,
        PH_P1    = 5'd17,
        PH_P2    = 5'd18,
        PH_P3    = 5'd19,
        PH_FIN   = 5'd20
    } t_phase;

    // configuration registers
    logic [iebm_pkg::DevAddrWidth-1:0]  r_device_address;
    logic [iebm_pkg::ByteWidth-1:0]     r_ack_timeout;
    logic [iebm_pkg::ByteWidth-1:0]     r_ticks_per_delay;

    // sequencer state
    t_phase                              r_phase,        n_phase;
    logic [iebm_pkg::BitCountWidth-1:0]  r_bit_count,    n_bit_count;
    logic [iebm_pkg::ByteWidth-1:0]      r_shift_byte,   n_shift_byte;
    logic [iebm_pkg::ByteWidth-1:0]      r_ack_wait,     n_ack_wait;
    logic [iebm_pkg::ByteWidth-1:0]      r_delay_count,  n_delay_count;
    logic                                r_is_read,      n_is_read;
    logic [iebm_pkg::ByteWidth-1:0]      r_held_address, n_held_address;
    logic [iebm_pkg::ByteWidth-1:0]      r_held_data,    n_held_data;
    logic                                r_scl_level,    n_scl_level;
    logic                                r_sda_level,    n_sda_level;
    logic [iebm_pkg::StageWidth-1:0]     r_stage,        n_stage;

    // result register
    logic                                r_out_valid;
    logic                                r_busy;
    logic                                r_done,         n_done;
    logic                                r_ok,           n_ok;
    logic [iebm_pkg::ByteWidth-1:0]      r_rdata,        n_rdata;

    logic                                w_in_xfer;
    logic [iebm_pkg::ByteWidth-1:0]      w_unit_reload;
    logic [iebm_pkg::ByteWidth-1:0]      w_dev_write;
    logic [iebm_pkg::ByteWidth-1:0]      w_dev_read;
    logic [iebm_pkg::StageWidth-1:0]     w_stage_inc;
    logic [iebm_pkg::BitCountWidth-1:0]  w_bit_inc;

    // result register frees up when empty or draining this cycle
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // reload for a new delay unit, zero ticks per delay acts as one
    assign w_unit_reload = (r_ticks_per_delay == '0) ? '0
                         : r_ticks_per_delay - iebm_pkg::ByteWidth'(1);
    assign w_dev_write   = {r_device_address, 1'b0};
    assign w_dev_read    = {r_device_address, 1'b1};
    assign w_stage_inc   = r_stage + iebm_pkg::StageWidth'(1);
    assign w_bit_inc     = r_bit_count + iebm_pkg::BitCountWidth'(1);

    // one sequencer step per tick
    always_comb begin
        n_phase        = r_phase;
        n_bit_count    = r_bit_count;
        n_shift_byte   = r_shift_byte;
        n_ack_wait     = r_ack_wait;
        n_delay_count  = r_delay_count;
        n_is_read      = r_is_read;
        n_held_address = r_held_address;
        n_held_data    = r_held_data;
        n_scl_level    = r_scl_level;
        n_sda_level    = r_sda_level;
        n_stage        = r_stage;
        n_done         = 1'b0;
        n_ok           = 1'b0;
        n_rdata        = '0;

        if (r_phase == PH_IDLE) begin
            if (i_cmd == iebm_pkg::CMD_WRITE || i_cmd == iebm_pkg::CMD_READ) begin
                n_is_read      = (i_cmd == iebm_pkg::CMD_READ);
                n_held_address = i_mem_address;
                n_held_data    = i_write_data;
                n_stage        = iebm_pkg::STAGE_DEVICE;
                n_sda_level    = 1'b1;
                n_delay_count  = w_unit_reload;
                n_phase        = PH_S2;
            end
        end else if (r_delay_count != '0) begin
            // unit still running, lines held
            n_delay_count = r_delay_count - iebm_pkg::ByteWidth'(1);
        end else begin
            unique case (r_phase)
                PH_S2: begin
                    n_scl_level   = 1'b1;
                    n_delay_count = w_unit_reload;
                    n_phase       = PH_S3;
                end
                PH_S3: begin
                    // start or repeated start, load device byte of this stage
                    n_sda_level   = 1'b0;
                    n_delay_count = w_unit_reload;
                    n_bit_count   = '0;
                    if (r_stage == iebm_pkg::STAGE_DEVICE) begin
                        n_shift_byte = w_dev_write;
                    end else if (r_stage == iebm_pkg::STAGE_ADDRESS) begin
                        n_shift_byte = r_held_address;
                    end else begin
                        n_shift_byte = r_is_read ? w_dev_read : r_held_data;
                    end
                    n_phase = PH_WLOW;
                end
                PH_WLOW: begin
                    n_scl_level   = 1'b0;
                    n_delay_count = w_unit_reload;
                    n_phase       = PH_WDATA;
                end
                PH_WDATA: begin
                    n_sda_level   = r_shift_byte[iebm_pkg::ByteWidth-1];
                    n_shift_byte  = {r_shift_byte[iebm_pkg::ByteWidth-2:0], 1'b0};
                    n_delay_count = w_unit_reload;
                    n_phase       = PH_WHIGH;
                end
                PH_WHIGH: begin
                    n_scl_level   = 1'b1;
                    n_delay_count = w_unit_reload;
                    n_bit_count   = w_bit_inc;
                    n_phase       = (w_bit_inc < iebm_pkg::BITS_PER_BYTE) ? PH_WLOW
                                                                          : PH_WEND1;
                end
                PH_WEND1: begin
                    n_scl_level   = 1'b0;
                    n_delay_count = w_unit_reload;
                    n_phase       = PH_WEND2;
                end
                PH_WEND2: begin
                    n_sda_level   = 1'b1;
                    n_scl_level   = 1'b1;
                    n_delay_count = w_unit_reload;
                    n_phase       = PH_ASET;
                end
                PH_ASET: begin
                    n_scl_level   = 1'b1;
                    n_delay_count = w_unit_reload;
                    n_ack_wait    = '0;
                    n_phase       = PH_ACHK;
                end
                PH_ACHK: begin
                    n_delay_count = w_unit_reload;
                    if (!i_sda_in) begin
                        n_scl_level = 1'b0;
                        n_phase     = PH_AOK;
                    end else if (r_ack_wait >= r_ack_timeout) begin
                        n_phase = PH_AFAIL;
                    end else begin
                        n_ack_wait = r_ack_wait + iebm_pkg::ByteWidth'(1);
                    end
                end
                PH_AFAIL: begin
                    // abort without stop, lines stay released
                    n_done  = 1'b1;
                    n_rdata = r_is_read ? iebm_pkg::READ_FAIL_DATA : '0;
                    n_phase = PH_IDLE;
                end
                PH_AOK: begin
                    if (r_stage == iebm_pkg::STAGE_DEVICE
                        || (r_stage == iebm_pkg::STAGE_ADDRESS && !r_is_read)) begin
                        n_stage     = w_stage_inc;
                        n_bit_count = '0;
                        n_shift_byte = (w_stage_inc == iebm_pkg::STAGE_ADDRESS)
                                       ? r_held_address : r_held_data;
                        n_phase     = PH_WLOW;
                    end else if (r_stage == iebm_pkg::STAGE_ADDRESS) begin
                        n_stage = iebm_pkg::STAGE_LAST;
                        n_phase = PH_RS1;
                    end else begin
                        n_phase = r_is_read ? PH_R1 : PH_P1;
                    end
                end
                PH_RS1: begin
                    n_sda_level   = 1'b1;
                    n_delay_count = w_unit_reload;
                    n_phase       = PH_S2;
                end
                PH_R1: begin
                    n_scl_level   = 1'b0;
                    n_delay_count = w_unit_reload;
                    n_phase       = PH_R2;
                end
                PH_R2: begin
                    n_sda_level   = 1'b1;
                    n_delay_count = w_unit_reload;
                    n_bit_count   = '0;
                    n_shift_byte  = '0;
                    n_phase       = PH_R3;
                end
                PH_R3: begin
                    n_scl_level   = 1'b1;
                    n_delay_count = w_unit_reload;
                    n_phase       = PH_R4;
                end
                PH_R4: begin
                    n_shift_byte  = {r_shift_byte[iebm_pkg::ByteWidth-2:0], i_sda_in};
                    n_scl_level   = 1'b0;
                    n_delay_count = w_unit_reload;
                    n_bit_count   = w_bit_inc;
                    n_phase       = (w_bit_inc < iebm_pkg::BITS_PER_BYTE) ? PH_R3 : PH_P1;
                end
                PH_P1: begin
                    n_sda_level   = 1'b0;
                    n_delay_count = w_unit_reload;
                    n_phase       = PH_P2;
                end
                PH_P2: begin
                    n_scl_level   = 1'b1;
                    n_delay_count = w_unit_reload;
                    n_phase       = PH_P3;
                end
                PH_P3: begin
                    n_sda_level   = 1'b1;
                    n_delay_count = w_unit_reload;
                    n_phase       = PH_FIN;
                end
                PH_FIN: begin
                    n_done  = 1'b1;
                    n_ok    = 1'b1;
                    n_rdata = r_is_read ? r_shift_byte : '0;
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address  <= iebm_pkg::RST_DEVICE_ADDRESS;
            r_ack_timeout     <= iebm_pkg::RST_ACK_TIMEOUT;
            r_ticks_per_delay <= iebm_pkg::RST_TICKS_PER_DELAY;
            r_phase           <= PH_IDLE;
            r_bit_count       <= '0;
            r_shift_byte      <= '0;
            r_ack_wait        <= '0;
            r_delay_count     <= '0;
            r_is_read         <= 1'b0;
            r_held_address    <= '0;
            r_held_data       <= '0;
            r_scl_level       <= 1'b1;
            r_sda_level       <= 1'b1;
            r_stage           <= iebm_pkg::STAGE_DEVICE;
            r_out_valid       <= 1'b0;
        end else begin
            // register writes, unknown indexes dropped
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    iebm_pkg::REG_DEVICE_ADDRESS:
                        r_device_address  <= i_cfg_data[iebm_pkg::DevAddrWidth-1:0];
                    iebm_pkg::REG_ACK_TIMEOUT:
                        r_ack_timeout     <= i_cfg_data;
                    iebm_pkg::REG_TICKS_PER_DELAY:
                        r_ticks_per_delay <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_in_xfer) begin
                r_phase        <= n_phase;
                r_bit_count    <= n_bit_count;
                r_shift_byte   <= n_shift_byte;
                r_ack_wait     <= n_ack_wait;
                r_delay_count  <= n_delay_count;
                r_is_read      <= n_is_read;
                r_held_address <= n_held_address;
                r_held_data    <= n_held_data;
                r_scl_level    <= n_scl_level;
                r_sda_level    <= n_sda_level;
                r_stage        <= n_stage;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_busy  <= (n_phase != PH_IDLE);
            r_done  <= n_done;
            r_ok    <= n_ok;
            r_rdata <= n_rdata;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_out   = r_scl_level;
    assign o_sda_out   = r_sda_level;
    assign o_busy_res  = r_busy;
    assign o_done_res  = r_done;
    assign o_success   = r_ok;
    assign o_read_data = r_rdata;

    // a finished transfer never reports busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done reported while busy");

    // success only accompanies done
    a_success_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_success |-> o_done_res)
        else $error("success without done");

    // a failed read returns all ones
    a_failed_read_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res && !o_success && r_is_read
        |-> o_read_data == iebm_pkg::READ_FAIL_DATA)
        else $error("failed read data not all ones");

    // a command taken from idle starts a transfer at once
    a_cmd_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && r_phase == PH_IDLE
        && (i_cmd == iebm_pkg::CMD_WRITE || i_cmd == iebm_pkg::CMD_READ)
        |=> o_out_valid && o_busy_res)
        else $error("command from idle did not start a transfer");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: i2c eeprom byte master
// drives bus ticks that act like an eeprom on the data line, predicts the
// line levels and completion flags of every tick and checks each result
// ----------------------------------------------------------------------------
module testbench;

    // command code that starts nothing, and the register index with no register
    localparam logic [iebm_pkg::CmdWidth-1:0]      CMD_NONE   = 2'd3;
    localparam logic [iebm_pkg::CfgIndexWidth-1:0] REG_UNUSED = 2'd3;
    // ack stage that never gets a missing acknowledge
    localparam int NO_NACK = 3;
    // ticks offered in each random phase
    localparam int PHASE_TICKS = 120;
    // long receiver hold-off, started a few results into the first random phase
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_OFFSET = 40;
    localparam int HOLD_NEVER  = 32'h7FFF_FFFF;

    // sequencer steps of the bus master
    typedef enum logic [4:0] {
        SEQ_IDLE, SEQ_START_SCL, SEQ_START_SDA, SEQ_BIT_LOW, SEQ_BIT_DATA,
        SEQ_BIT_HIGH, SEQ_BYTE_END_LOW, SEQ_BYTE_END_REL, SEQ_ACK_SETUP,
        SEQ_ACK_POLL, SEQ_ACK_FAIL, SEQ_ACK_OK, SEQ_RESTART, SEQ_RD_LOW,
        SEQ_RD_REL, SEQ_RD_HIGH, SEQ_RD_SAMPLE, SEQ_STOP_LOW, SEQ_STOP_SCL,
        SEQ_STOP_SDA, SEQ_FINISH
    } t_seq_phase;

    // what the block reports after one tick
    typedef struct packed {
        logic                           scl;
        logic                           sda;
        logic                           busy;
        logic                           done;
        logic                           success;
        logic [iebm_pkg::ByteWidth-1:0] rdata;
    } t_bus_state;

    // ------------------------------------------------------------------------
    // tick predictor plus the queue of predicted bus states
    // ------------------------------------------------------------------------
    class eeprom_master_scoreboard;
        logic [iebm_pkg::DevAddrWidth-1:0]  dev_addr;
        logic [iebm_pkg::ByteWidth-1:0]     ack_timeout;
        logic [iebm_pkg::ByteWidth-1:0]     ticks_per_delay;

        t_seq_phase                         phase;
        logic [iebm_pkg::BitCountWidth-1:0] bit_count;
        logic [iebm_pkg::ByteWidth-1:0]     shift_byte;
        logic [iebm_pkg::ByteWidth-1:0]     ack_wait_count;
        logic [iebm_pkg::ByteWidth-1:0]     delay_count;
        logic                               is_read;
        logic [iebm_pkg::ByteWidth-1:0]     held_address;
        logic [iebm_pkg::ByteWidth-1:0]     held_data;
        logic                               scl_level;
        logic                               sda_level;
        logic [iebm_pkg::StageWidth-1:0]    stage;

        t_bus_state                         due_states[$];
        int                                 fault_count;

        function void reset_state();
            dev_addr        = iebm_pkg::RST_DEVICE_ADDRESS;
            ack_timeout     = iebm_pkg::RST_ACK_TIMEOUT;
            ticks_per_delay = iebm_pkg::RST_TICKS_PER_DELAY;
            phase           = SEQ_IDLE;
            bit_count       = '0;
            shift_byte      = '0;
            ack_wait_count  = '0;
            delay_count     = '0;
            is_read         = 1'b0;
            held_address    = '0;
            held_data       = '0;
            scl_level       = 1'b1;
            sda_level       = 1'b1;
            stage           = iebm_pkg::STAGE_DEVICE;
            due_states.delete();
            fault_count     = 0;
        endfunction

        function void write_register(logic [iebm_pkg::CfgIndexWidth-1:0] index,
                                     logic [iebm_pkg::CfgDataWidth-1:0] value);
            case (index)
                iebm_pkg::REG_DEVICE_ADDRESS:
                    dev_addr = value[iebm_pkg::DevAddrWidth-1:0];
                iebm_pkg::REG_ACK_TIMEOUT:     ack_timeout = value;
                iebm_pkg::REG_TICKS_PER_DELAY: ticks_per_delay = value;
                default: ;
            endcase
        endfunction

        // a zero tick count behaves as one tick per unit
        function void start_unit();
            delay_count = (ticks_per_delay == 0) ? 8'd0 : ticks_per_delay - 8'd1;
        endfunction

        function void load_byte();
            if (stage == iebm_pkg::STAGE_DEVICE)
                shift_byte = {dev_addr, 1'b0};
            else if (stage == iebm_pkg::STAGE_ADDRESS)
                shift_byte = held_address;
            else
                shift_byte = is_read ? {dev_addr, 1'b1} : held_data;
            bit_count = '0;
        endfunction

        function int pending();
            return due_states.size();
        endfunction

        function void accept_tick(logic [iebm_pkg::CmdWidth-1:0] cmd,
                                  logic [iebm_pkg::ByteWidth-1:0] addr,
                                  logic [iebm_pkg::ByteWidth-1:0] data, logic sda);
            t_bus_state st;
            st = '0;
            if (phase == SEQ_IDLE) begin
                if (cmd == iebm_pkg::CMD_WRITE || cmd == iebm_pkg::CMD_READ) begin
                    is_read      = (cmd == iebm_pkg::CMD_READ);
                    held_address = addr;
                    held_data    = data;
                    stage        = iebm_pkg::STAGE_DEVICE;
                    sda_level    = 1'b1;
                    start_unit();
                    phase = SEQ_START_SCL;
                end
            end else if (delay_count != 0) begin
                delay_count = delay_count - 8'd1;
            end else begin
                case (phase)
                    SEQ_START_SCL: begin
                        scl_level = 1'b1; start_unit(); phase = SEQ_START_SDA;
                    end
                    SEQ_START_SDA: begin
                        sda_level = 1'b0; start_unit(); load_byte(); phase = SEQ_BIT_LOW;
                    end
                    SEQ_BIT_LOW: begin
                        scl_level = 1'b0; start_unit(); phase = SEQ_BIT_DATA;
                    end
                    SEQ_BIT_DATA: begin
                        sda_level  = shift_byte[7];
                        shift_byte = shift_byte << 1;
                        start_unit(); phase = SEQ_BIT_HIGH;
                    end
                    SEQ_BIT_HIGH: begin
                        scl_level = 1'b1; start_unit();
                        bit_count = bit_count + 4'd1;
                        phase = (bit_count < iebm_pkg::BITS_PER_BYTE) ? SEQ_BIT_LOW
                                                                      : SEQ_BYTE_END_LOW;
                    end
                    SEQ_BYTE_END_LOW: begin
                        scl_level = 1'b0; start_unit(); phase = SEQ_BYTE_END_REL;
                    end
                    SEQ_BYTE_END_REL: begin
                        sda_level = 1'b1; scl_level = 1'b1; start_unit();
                        phase = SEQ_ACK_SETUP;
                    end
                    SEQ_ACK_SETUP: begin
                        scl_level = 1'b1; start_unit(); ack_wait_count = '0;
                        phase = SEQ_ACK_POLL;
                    end
                    SEQ_ACK_POLL: begin
                        if (!sda) begin
                            scl_level = 1'b0; start_unit(); phase = SEQ_ACK_OK;
                        end else begin
                            start_unit();
                            if (ack_wait_count >= ack_timeout)
                                phase = SEQ_ACK_FAIL;
                            else
                                ack_wait_count = ack_wait_count + 8'd1;
                        end
                    end
                    SEQ_ACK_FAIL: begin
                        st.done  = 1'b1;
                        st.rdata = is_read ? iebm_pkg::READ_FAIL_DATA : 8'h00;
                        phase = SEQ_IDLE;
                    end
                    SEQ_ACK_OK: begin
                        if (stage == iebm_pkg::STAGE_DEVICE
                            || (stage == iebm_pkg::STAGE_ADDRESS && !is_read)) begin
                            stage = stage + 2'd1; load_byte(); phase = SEQ_BIT_LOW;
                        end else if (stage == iebm_pkg::STAGE_ADDRESS) begin
                            stage = iebm_pkg::STAGE_LAST; phase = SEQ_RESTART;
                        end else begin
                            phase = is_read ? SEQ_RD_LOW : SEQ_STOP_LOW;
                        end
                    end
                    SEQ_RESTART: begin
                        sda_level = 1'b1; start_unit(); phase = SEQ_START_SCL;
                    end
                    SEQ_RD_LOW: begin
                        scl_level = 1'b0; start_unit(); phase = SEQ_RD_REL;
                    end
                    SEQ_RD_REL: begin
                        sda_level = 1'b1; start_unit(); bit_count = '0; shift_byte = '0;
                        phase = SEQ_RD_HIGH;
                    end
                    SEQ_RD_HIGH: begin
                        scl_level = 1'b1; start_unit(); phase = SEQ_RD_SAMPLE;
                    end
                    SEQ_RD_SAMPLE: begin
                        shift_byte = {shift_byte[6:0], sda};
                        scl_level  = 1'b0; start_unit();
                        bit_count  = bit_count + 4'd1;
                        phase = (bit_count < iebm_pkg::BITS_PER_BYTE) ? SEQ_RD_HIGH
                                                                      : SEQ_STOP_LOW;
                    end
                    SEQ_STOP_LOW: begin
                        sda_level = 1'b0; start_unit(); phase = SEQ_STOP_SCL;
                    end
                    SEQ_STOP_SCL: begin
                        scl_level = 1'b1; start_unit(); phase = SEQ_STOP_SDA;
                    end
                    SEQ_STOP_SDA: begin
                        sda_level = 1'b1; start_unit(); phase = SEQ_FINISH;
                    end
                    SEQ_FINISH: begin
                        st.done    = 1'b1;
                        st.success = 1'b1;
                        st.rdata   = is_read ? shift_byte : 8'h00;
                        phase = SEQ_IDLE;
                    end
                    default: phase = SEQ_IDLE;
                endcase
            end
            st.scl  = scl_level;
            st.sda  = sda_level;
            st.busy = (phase != SEQ_IDLE);
            due_states.push_back(st);
        endfunction

        function void check_bus_state(t_bus_state got);
            t_bus_state want;
            if (due_states.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: scl %0b sda %0b busy %0b done %0b %s",
                             got.scl, got.sda, got.busy, got.done,
                             $sformatf("ok %0b data %02h", got.success, got.rdata));
                return;
            end
            want = due_states.pop_front();
            if (got.scl !== want.scl || got.sda !== want.sda || got.busy !== want.busy ||
                got.done !== want.done || got.success !== want.success ||
                got.rdata !== want.rdata) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("mismatch at %0t: expected scl %0b sda %0b busy %0b done %0b %s",
                             $realtime, want.scl, want.sda, want.busy, want.done,
                             $sformatf("ok %0b data %02h", want.success, want.rdata));
                    $display("                  actual scl %0b sda %0b busy %0b done %0b %s",
                             got.scl, got.sda, got.busy, got.done,
                             $sformatf("ok %0b data %02h", got.success, got.rdata));
                end
            end
        endfunction

        // predictions that never got a result count as failures
        function void flush_missing();
            if (due_states.size() != 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("%0d expected results never arrived", due_states.size());
                due_states.delete();
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                i_in_valid    = 1'b0;
    logic                                o_in_ready;
    logic [iebm_pkg::CmdWidth-1:0]       i_cmd         = iebm_pkg::CMD_TICK;
    logic [iebm_pkg::ByteWidth-1:0]      i_mem_address = '0;
    logic [iebm_pkg::ByteWidth-1:0]      i_write_data  = '0;
    logic                                i_sda_in      = 1'b1;
    logic                                o_out_valid;
    logic                                i_out_ready   = 1'b0;
    logic                                o_scl_out;
    logic                                o_sda_out;
    logic                                o_busy_res;
    logic                                o_done_res;
    logic                                o_success;
    logic [iebm_pkg::ByteWidth-1:0]      o_read_data;
    logic                                i_cfg_valid   = 1'b0;
    logic                                o_cfg_ready;
    logic [iebm_pkg::CfgIndexWidth-1:0]  i_cfg_index   = '0;
    logic [iebm_pkg::CfgDataWidth-1:0]   i_cfg_data    = '0;

    // idling percentages of the current phase
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    // transfer bookkeeping and the one long receiver hold-off
    int items_sent    = 0;
    int results_taken = 0;
    int hold_at       = HOLD_NEVER;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    eeprom_master_scoreboard sb;

    i2c_eeprom_byte_master uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_mem_address (i_mem_address),
        .i_write_data  (i_write_data),
        .i_sda_in      (i_sda_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_scl_out     (o_scl_out),
        .o_sda_out     (o_sda_out),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_success     (o_success),
        .o_read_data   (o_read_data),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 20 ns clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, one long hold-off, and the result check
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_bus_state got;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            // a result transfer happens on valid and ready at this edge
            if (o_out_valid && i_out_ready) begin
                got = {o_scl_out, o_sda_out, o_busy_res, o_done_res, o_success, o_read_data};
                sb.check_bus_state(got);
                results_taken++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && results_taken >= hold_at) begin
                // long hold-off: the one-deep result register fills and the
                // tick input stalls while the sender keeps offering
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------

    // offer one tick, hold it until the transfer, then predict its result
    task automatic send_tick(input logic [iebm_pkg::CmdWidth-1:0] cmd,
                             input logic [iebm_pkg::ByteWidth-1:0] addr,
                             input logic [iebm_pkg::ByteWidth-1:0] data, input logic sda);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_mem_address <= addr;
        i_write_data  <= data;
        i_sda_in      <= sda;
        do @(posedge i_clk); while (!o_in_ready);
        sb.accept_tick(cmd, addr, data, sda);
        items_sent++;
    endtask

    // data line as an eeprom would drive it for the next tick: acknowledge
    // low, or late when slow, unless this byte is the one to be refused, random bits elsewhere
    function automatic logic eeprom_sda(input int nack_stage, input bit slow_ack);
        if (sb.phase == SEQ_ACK_POLL) begin
            if (int'(sb.stage) == nack_stage)
                return 1'b1;
            if (slow_ack)
                return ($urandom_range(3) != 0);
            return 1'b0;
        end
        return 1'($urandom_range(1));
    endfunction

    // ticks until the block is idle again; noise_pct percent of them carry a
    // random command code that must be ignored
    task automatic finish_transfer(input int nack_stage, input bit slow_ack,
                                   input int noise_pct);
        logic [iebm_pkg::CmdWidth-1:0] cmd;
        while (sb.phase != SEQ_IDLE) begin
            cmd = ($urandom_range(99) < noise_pct)
                  ? iebm_pkg::CmdWidth'($urandom_range(3)) : iebm_pkg::CMD_TICK;
            send_tick(cmd, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      eeprom_sda(nack_stage, slow_ack));
        end
    endtask

    // one byte write or random read from idle until the block is idle again
    task automatic run_transfer(input logic [iebm_pkg::CmdWidth-1:0] kind,
                                input logic [iebm_pkg::ByteWidth-1:0] addr,
                                input logic [iebm_pkg::ByteWidth-1:0] data,
                                input int nack_stage, input bit slow_ack, input int noise_pct);
        send_tick(kind, addr, data, 1'($urandom_range(1)));
        finish_transfer(nack_stage, slow_ack, noise_pct);
    endtask

    // plain ticks while idle, code 3 included
    task automatic idle_ticks(input int count);
        repeat (count)
            send_tick($urandom_range(1) ? iebm_pkg::CMD_TICK : CMD_NONE,
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      1'($urandom_range(1)));
    endtask

    // plain ticks in the middle of a transfer
    task automatic busy_ticks(input int count);
        repeat (count)
            send_tick(iebm_pkg::CMD_TICK, 8'($urandom_range(255)),
                      8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // wait until every predicted result has come, then idle before going on
    task automatic settle();
        int waited;
        i_in_valid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        sb.flush_missing();
        repeat (4) @(posedge i_clk);
    endtask

    // write all registers, and the unused index, back to back
    task automatic set_config(input logic [iebm_pkg::CfgDataWidth-1:0] dev,
                              input logic [iebm_pkg::CfgDataWidth-1:0] timeout,
                              input logic [iebm_pkg::CfgDataWidth-1:0] tpd);
        logic [iebm_pkg::CfgIndexWidth-1:0] idx_list [4];
        logic [iebm_pkg::CfgDataWidth-1:0]  val_list [4];
        idx_list[0] = iebm_pkg::REG_DEVICE_ADDRESS;  val_list[0] = dev;
        idx_list[1] = iebm_pkg::REG_ACK_TIMEOUT;     val_list[1] = timeout;
        idx_list[2] = iebm_pkg::REG_TICKS_PER_DELAY; val_list[2] = tpd;
        idx_list[3] = REG_UNUSED;                    val_list[3] = 8'($urandom_range(255));
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx_list[k];
            i_cfg_data  <= val_list[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_register(idx_list[k], val_list[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // random transfer: mostly well formed, some refused acknowledges
    task automatic random_transfer(input bit nack_ok);
        logic [iebm_pkg::CmdWidth-1:0] kind;
        int                            nack_stage;
        kind = $urandom_range(1) ? iebm_pkg::CMD_READ : iebm_pkg::CMD_WRITE;
        nack_stage = (nack_ok && $urandom_range(99) < 15) ? $urandom_range(2) : NO_NACK;
        run_transfer(kind, 8'($urandom_range(255)), 8'($urandom_range(255)), nack_stage,
                     ($urandom_range(3) == 0), 10);
        idle_ticks($urandom_range(2));
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [iebm_pkg::CfgDataWidth-1:0] cfg_timeout;
        logic [iebm_pkg::CfgDataWidth-1:0] cfg_tpd;
        int                                eff_tpd;
        bit                                nack_ok;
        int                                phase_end;

        sb = new();
        sb.reset_state();

        // reset held once at the start
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sb.reset_state();

        // register reset values; commands on every busy tick, the finishing one included
        run_transfer(iebm_pkg::CMD_WRITE, 8'hC3, 8'h3C, NO_NACK, 1'b0, 100);
        // read with a slow acknowledge under the default timeout
        run_transfer(iebm_pkg::CMD_READ, 8'h96, 8'h69, NO_NACK, 1'b1, 0);
        idle_ticks(3);

        // zero timeout and zero tick count, missing acknowledge on the address
        // byte of a write, no stop
        settle();
        set_config(8'h00, 8'd0, 8'd0);
        run_transfer(iebm_pkg::CMD_WRITE, 8'h81, 8'h7E, int'(iebm_pkg::STAGE_ADDRESS),
                     1'b0, 0);

        // widest settings, top bit of the device byte masked off; the first
        // delay unit runs down at full length, the rest goes at one tick a unit
        settle();
        set_config(8'hFF, 8'd255, 8'd255);
        send_tick(iebm_pkg::CMD_WRITE, 8'h7E, 8'h81, 1'b1);
        busy_ticks(254);
        settle();
        set_config(8'hFF, 8'd255, 8'd1);
        finish_transfer(NO_NACK, 1'b0, 0);

        // timeout of one and two ticks per unit, failed read reports all ones
        settle();
        set_config(8'h2A, 8'd1, 8'd2);
        run_transfer(iebm_pkg::CMD_READ, 8'h24, 8'hDB, int'(iebm_pkg::STAGE_DEVICE),
                     1'b0, 0);

        // random part: four idling phases, one setting each
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 54; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 54; end
                default: begin sender_idle_pct = 29; receiver_stall_pct = 29; end
            endcase
            settle();
            case ($urandom_range(4))
                0: cfg_timeout = 8'd0;
                1: cfg_timeout = 8'd1;
                2: cfg_timeout = 8'd255;
                default: cfg_timeout = 8'($urandom_range(250, 2));
            endcase
            case ($urandom_range(5))
                0: cfg_tpd = 8'd0;
                4: cfg_tpd = 8'd2;
                5: cfg_tpd = 8'd3;
                default: cfg_tpd = 8'd1;
            endcase
            set_config(8'($urandom_range(255)), cfg_timeout, cfg_tpd);
            // refused acknowledges only where the timeout stays short
            eff_tpd = (cfg_tpd == 0) ? 1 : int'(cfg_tpd);
            nack_ok = ((int'(cfg_timeout) + 1) * eff_tpd <= 1024);
            // long hold-off shortly after the first random transfer starts
            if (p == 0)
                hold_at = results_taken + HOLD_OFFSET;
            phase_end = items_sent + PHASE_TICKS;
            while (items_sent < phase_end)
                random_transfer(nack_ok);
        end

        // drain and report
        settle();
        if (sb.fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
